// ===== src/rlbm_pkg.sv =====
package rlbm_pkg;

	localparam int SAMPLE_DEPTH_DEF  = 512;
	localparam int HISTORY_DEPTH_DEF = 30;
	localparam int SAMPLE_BITS_DEF   = 16;

	localparam int CFG_W = 16;
	localparam int OUT_W = 16;

	// configuration register indexes
	localparam logic [1:0] REG_INTERVAL = 2'd0;
	localparam logic [1:0] REG_SILENCE  = 2'd1;
	localparam logic [1:0] REG_CLAMP    = 2'd2;
	localparam logic [1:0] REG_GAIN     = 2'd3;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	typedef struct packed {
		logic        func;
		logic [15:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [15:0] bar_height;
		logic [15:0] rms_level;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_SQ_OLD,
		ST_SQ_NEW,
		ST_DIV,
		ST_SQRT,
		ST_HIST,
		ST_MAX,
		ST_FDIV,
		ST_GAIN
	} state_t;

endpackage

// ===== src/rms_level_bar_meter_unit.sv =====
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | in_item_t  {func, sample}
// out     | out | out_valid / out_ready| out_item_t {bar_height, rms_level}
// cfg     | in  | cfg_we               | cfg_index, cfg_data
// A sample item passes through ST_SQ_NEW, after ST_RD_OLD and ST_SQ_OLD once the ring is
// full (old entry read, old and new squares on the shared multiplier). A tick item that
// does not fire only advances the tick count. A firing tick runs the mean division (one
// quotient bit a cycle), square root (two radicand bits a cycle), history write, max scan
// (one entry a cycle), 31-step fraction division and the gain multiply. The result waits
// in the output register while new items are taken; a later firing tick holds in the gain
// step, with in_ready low, until that register is free. arst_n clears all control state
// and the history.
module rms_level_bar_meter_unit
	import rlbm_pkg::*;
#(
	parameter int SAMPLE_DEPTH  = SAMPLE_DEPTH_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	// sample width is fixed by the item format
	localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int AW   = $clog2(SAMPLE_DEPTH);
	localparam int CW   = $clog2(SAMPLE_DEPTH + 1);
	localparam int SQW  = 2 * SAMPLE_BITS;
	// sum width kept even so the root walks two bits a step
	localparam int SUMW = SQW + CW + (CW % 2);
	localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int RW   = SUMW / 2 + 1;
	localparam int SQ_STEPS = SUMW / 2;
	localparam int FD_STEPS = 31;
	localparam int SCW  = $clog2(((SUMW > FD_STEPS) ? SUMW : FD_STEPS) + 1);
	localparam logic [OUT_W-1:0] FLOOR = OUT_W'((1 << (SAMPLE_BITS - 1)) / 10000);
	localparam logic [16:0] Q15_ONE = 17'd32768;

	// configuration registers
	logic [5:0]  interval_q;
	logic [15:0] silence_q, clamp_q, gain_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 6'd6;
			silence_q  <= 16'd33;
			clamp_q    <= 16'd655;
			gain_q     <= 16'd26214;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data[5:0];
				REG_SILENCE:  silence_q  <= cfg_data;
				REG_CLAMP:    clamp_q    <= cfg_data;
				REG_GAIN:     gain_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	state_t state_q, state_d;

	// sample ring memory
	logic [SAMPLE_BITS-1:0] ring_mem [SAMPLE_DEPTH];
	logic [SAMPLE_BITS-1:0] ring_rd_q;
	logic [AW-1:0]          wp_q;
	logic [CW-1:0]          held_q;
	logic [SUMW-1:0]        sum_q;
	logic [SAMPLE_BITS-1:0] smp_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready && in_item.func == FUNC_SAMPLE)
			ring_mem[wp_q] <= in_item.sample[SAMPLE_BITS-1:0];
		// hold the entry about to be overwritten until its square is taken off
		if (state_q == ST_IDLE)
			ring_rd_q <= ring_mem[wp_q];
	end

	// iterative datapath registers
	logic [SUMW-1:0]  rem_q;     // division remainder / sqrt radicand
	logic [SUMW-1:0]  quo_q;     // division quotient
	logic [SCW-1:0]   cnt_q;
	logic [RW-1:0]    root_q;
	logic [RW+1:0]    srem_q;
	logic [15:0]      rms_q;
	logic [15:0]      hist_q [HISTORY_DEPTH];
	logic [HW-1:0]    hp_q;
	logic [HW-1:0]    hi_q;
	logic [15:0]      max_q;
	logic [30:0]      frac_q;    // dividend bits out the top, quotient bits in
	logic [16:0]      frem_q;
	logic [5:0]       tick_q;
	out_item_t        out_q;
	logic             out_v_q;

	// shared multiplier, operands chosen by state
	logic signed [SAMPLE_BITS:0] mul_a, mul_b;
	logic signed [2*SAMPLE_BITS+1:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ_OLD: begin
				mul_a = {ring_rd_q[SAMPLE_BITS-1], ring_rd_q};
				mul_b = mul_a;
			end
			ST_SQ_NEW: begin
				mul_a = {smp_q[SAMPLE_BITS-1], smp_q};
				mul_b = mul_a;
			end
			ST_GAIN: begin
				mul_a = {1'b0, frac_q[15:0]};
				mul_b = {1'b0, gain_q};
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// one restoring step of the mean division
	logic [SUMW:0]  div_trial;
	logic [SUMW:0]  div_sh;
	logic           div_bit;
	always_comb begin
		div_sh    = {rem_q, quo_q[SUMW-1]};
		div_trial = div_sh - (SUMW+1)'(held_q);
		div_bit   = !div_trial[SUMW] && (held_q != '0);
	end

	// one sqrt step: two radicand bits a cycle
	logic [RW+1:0] sq_rem_sh;
	logic [RW+1:0] sq_trial;
	logic          root_bit;
	logic [RW-1:0] root_next;
	always_comb begin
		sq_rem_sh = {srem_q[RW-1:0], rem_q[SUMW-1 -: 2]};
		sq_trial  = sq_rem_sh - (RW+2)'({root_q, 2'b01});
		root_bit  = !sq_trial[RW+1];
		root_next = {root_q[RW-2:0], root_bit};
	end

	// fraction division step: (rms<<15)/max over 31 dividend bits
	logic [17:0] f_sh;
	logic [17:0] f_trial;
	logic [30:0] frac_next;
	always_comb begin
		f_sh      = {frem_q, frac_q[30]};
		f_trial   = f_sh - 18'(max_q);
		frac_next = {frac_q[29:0], !f_trial[17]};
	end

	logic [5:0] interval_eff;
	assign interval_eff = (interval_q == 6'd0) ? 6'd1 : interval_q;
	logic [5:0] tick_next;
	assign tick_next = tick_q + 6'd1;

	// result slot free for a new result this cycle
	logic out_free;
	assign out_free = !out_v_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) begin
				if (in_item.func == FUNC_SAMPLE)
					state_d = (held_q >= CW'(SAMPLE_DEPTH)) ? ST_RD_OLD : ST_SQ_NEW;
				else if (tick_next >= interval_eff)
					state_d = ST_DIV;
			end
			ST_RD_OLD: state_d = ST_SQ_OLD;
			ST_SQ_OLD: state_d = ST_SQ_NEW;
			ST_SQ_NEW: state_d = ST_IDLE;
			ST_DIV:  if (cnt_q == SCW'(SUMW - 1)) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == SCW'(SQ_STEPS - 1)) state_d = ST_HIST;
			ST_HIST: state_d = ST_MAX;
			ST_MAX:  if (hi_q == HW'(HISTORY_DEPTH - 1)) state_d = ST_FDIV;
			ST_FDIV: if (cnt_q == SCW'(FD_STEPS - 1)) state_d = ST_GAIN;
			ST_GAIN: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = out_v_q;
		out_item  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			held_q  <= '0;
			sum_q   <= '0;
			hp_q    <= '0;
			tick_q  <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
			cnt_q   <= '0;
			hi_q    <= '0;
			smp_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			root_q  <= '0;
			srem_q  <= '0;
			rms_q   <= '0;
			max_q   <= '0;
			frac_q  <= '0;
			frem_q  <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else begin
			state_q <= state_d;
			// result register: load from the gain step, else drain on accept
			if (state_q == ST_GAIN && out_free) out_v_q <= 1'b1;
			else if (out_v_q && out_ready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					smp_q  <= in_item.sample[SAMPLE_BITS-1:0];
					cnt_q  <= '0;
					if (in_item.func == FUNC_TICK) begin
						if (tick_next >= interval_eff) begin
							tick_q <= '0;
							rem_q  <= '0;
							quo_q  <= sum_q;
						end else
							tick_q <= tick_next;
					end
				end
				ST_SQ_OLD: sum_q <= sum_q - SUMW'(mul_p[SQW-1:0]);
				ST_SQ_NEW: begin
					sum_q <= sum_q + SUMW'(mul_p[SQW-1:0]);
					if (held_q < CW'(SAMPLE_DEPTH)) held_q <= held_q + 1'b1;
					wp_q <= (wp_q == AW'(SAMPLE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				end
				ST_DIV: begin
					quo_q <= {quo_q[SUMW-2:0], div_bit};
					if (cnt_q == SCW'(SUMW - 1)) begin
						// finished quotient (0 if no samples held) is the radicand
						rem_q  <= {quo_q[SUMW-2:0], div_bit};
						cnt_q  <= '0;
						root_q <= '0;
						srem_q <= '0;
					end else begin
						rem_q <= div_bit ? div_trial[SUMW-1:0] : div_sh[SUMW-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					srem_q <= root_bit ? sq_trial : sq_rem_sh;
					root_q <= root_next;
					rem_q  <= {rem_q[SUMW-3:0], 2'b00};
					cnt_q  <= cnt_q + 1'b1;
					// silence gate on the finished root
					if (cnt_q == SCW'(SQ_STEPS - 1))
						rms_q <= (root_next < RW'(silence_q)) ? 16'd0 : 16'(root_next);
				end
				ST_HIST: begin
					hist_q[hp_q] <= rms_q;
					hp_q  <= (hp_q == HW'(HISTORY_DEPTH - 1)) ? '0 : hp_q + 1'b1;
					hi_q  <= '0;
					max_q <= FLOOR;
				end
				ST_MAX: begin
					if (hist_q[hi_q] > max_q) max_q <= hist_q[hi_q];
					if (hi_q == HW'(HISTORY_DEPTH - 1)) begin
						hi_q   <= '0;
						cnt_q  <= '0;
						frem_q <= '0;
						frac_q <= {rms_q, 15'd0};
					end else
						hi_q <= hi_q + 1'b1;
				end
				ST_FDIV: begin
					frem_q <= f_trial[17] ? f_sh[16:0] : f_trial[16:0];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == SCW'(FD_STEPS - 1)) begin
						// no usable maximum, or below the clamp: zero height
						if (max_q <= FLOOR || frac_next < 31'(clamp_q)) frac_q <= '0;
						else frac_q <= frac_next;
					end else
						frac_q <= frac_next;
				end
				ST_GAIN: if (out_free) begin
					out_q.rms_level  <= rms_q;
					out_q.bar_height <= (mul_p[33:14] > 20'(Q15_ONE)) ? 16'h8000
						: mul_p[29:14];
				end
				default: ;
			endcase
		end
	end

endmodule
